[hw/rtl/stream_group_reverser_unit_macros.svh]
// Assertion macros used by the port-level checker of the group reverser.
`ifndef STREAM_GROUP_REVERSER_UNIT_MACROS_SVH
`define STREAM_GROUP_REVERSER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SGR_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SGR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define SGR_ASSERT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hw/rtl/sgr_pkg.sv]
// Types and constants of the stream group reverser.
`default_nettype none

package sgr_pkg;

   localparam int GROUP_MAX = 16;
   localparam int ADDR_W    = $clog2(GROUP_MAX);
   localparam int COUNT_W   = $clog2(GROUP_MAX + 1);
   localparam int CFG_W     = 5;
   localparam int VALUE_W   = 32;

   localparam logic [CFG_W-1:0] GROUP_SIZE_RESET = CFG_W'(2);

   typedef struct packed {
      logic signed [VALUE_W-1:0] item_value;
      logic                      list_end;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] out_value;
      logic                      run_last;
      logic                      sequence_last;
   } rsp_payload_type;

endpackage

`default_nettype wire

[hw/rtl/stream_group_reverser_unit.sv]
// Stream group reverser: buffers items; emits each full group reversed and a group closed
// early by a list end in arrival order. Each result passes the read register, then the
// output register. An item that opens no emission is taken without a stall; an item that
// closes a group stalls input while the group buffer's single read port reads it out.
// Results leave at one per cycle within a group while the result side does not stall.
// Reset: fill count cleared, group size set to 2; buffer contents are not cleared.
`default_nettype none

module stream_group_reverser_unit (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire sgr_pkg::req_payload_type       req_payload,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output sgr_pkg::rsp_payload_type            rsp_payload,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [sgr_pkg::CFG_W-1:0]      csr_data
);
   import sgr_pkg::*;

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_EMIT = 1'b1;

   logic [VALUE_W-1:0] group_mem [GROUP_MAX];

   logic               state_ff, state_in;
   logic [COUNT_W-1:0] fill_ff, fill_in;
   logic [CFG_W-1:0]   group_size_ff, group_size_in;
   logic [ADDR_W-1:0]  cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  last_idx_ff, last_idx_in;
   logic               reverse_ff, reverse_in;
   logic               ending_ff, ending_in;

   logic               rd_valid_ff, rd_valid_in;
   logic [VALUE_W-1:0] rd_data_ff;
   logic               rd_run_last_ff;
   logic               rd_seq_last_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   rsp_payload_type    rsp_payload_ff;

   logic               req_take;
   logic [COUNT_W-1:0] k_eff;
   logic [COUNT_W-1:0] n_count;
   logic               full_group;
   logic               rsp_load;
   logic               issue;
   logic               issue_last;
   logic [ADDR_W-1:0]  rd_addr;

   assign req_stall = (state_ff == STATE_EMIT);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   // Clamp the group size into 1 .. GROUP_MAX.
   always_comb begin
      if (group_size_ff == '0) begin
         k_eff = COUNT_W'(1);
      end else if (8'(group_size_ff) > 8'(GROUP_MAX)) begin
         k_eff = COUNT_W'(GROUP_MAX);
      end else begin
         k_eff = COUNT_W'(group_size_ff);
      end
   end

   assign n_count    = fill_ff + COUNT_W'(1);
   assign full_group = (n_count >= k_eff);

   // Read stage advances into the output register when that register frees up.
   assign rsp_load   = rd_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue      = (state_ff == STATE_EMIT) && (!rd_valid_ff || rsp_load);
   assign issue_last = (cnt_ff == last_idx_ff);
   assign rd_addr    = reverse_ff ? (last_idx_ff - cnt_ff) : cnt_ff;

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      cnt_in        = cnt_ff;
      last_idx_in   = last_idx_ff;
      reverse_in    = reverse_ff;
      ending_in     = ending_ff;
      group_size_in = group_size_ff;

      if (csr_valid && csr_ready) begin
         group_size_in = csr_data;
      end

      case (state_ff)
         STATE_IDLE: begin
            if (req_take) begin
               if (full_group || req_payload.list_end) begin
                  state_in    = STATE_EMIT;
                  fill_in     = '0;
                  cnt_in      = '0;
                  last_idx_in = fill_ff[ADDR_W-1:0];
                  reverse_in  = full_group;
                  ending_in   = req_payload.list_end;
               end else begin
                  fill_in = n_count;
               end
            end
         end
         STATE_EMIT: begin
            if (issue) begin
               cnt_in = cnt_ff + ADDR_W'(1);
               if (issue_last) begin
                  state_in = STATE_IDLE;
               end
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_comb begin
      if (issue) begin
         rd_valid_in = 1'b1;
      end else if (rsp_load) begin
         rd_valid_in = 1'b0;
      end else begin
         rd_valid_in = rd_valid_ff;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= STATE_IDLE;
         fill_ff       <= '0;
         group_size_ff <= GROUP_SIZE_RESET;
         cnt_ff        <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         group_size_ff <= group_size_in;
         cnt_ff        <= cnt_in;
         rd_valid_ff   <= rd_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_idx_ff <= last_idx_in;
      reverse_ff  <= reverse_in;
      ending_ff   <= ending_in;
   end

   // Group buffer: write on accept, registered read while emitting.
   always_ff @(posedge clock) begin
      if (req_take) begin
         group_mem[fill_ff[ADDR_W-1:0]] <= req_payload.item_value;
      end
      if (issue) begin
         rd_data_ff     <= group_mem[rd_addr];
         rd_run_last_ff <= issue_last;
         rd_seq_last_ff <= issue_last && ending_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_payload_ff.out_value     <= rd_data_ff;
         rsp_payload_ff.run_last      <= rd_run_last_ff;
         rsp_payload_ff.sequence_last <= rd_seq_last_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

endmodule

`default_nettype wire

[hw/rtl/sgr_checker.sv]
// Port-level checks of the group reverser, bound into the reverser module.
`default_nettype none

`include "stream_group_reverser_unit_macros.svh"

module sgr_checker (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   input  wire logic                           req_stall,
   input  wire sgr_pkg::req_payload_type       req_payload,
   input  wire logic                           rsp_valid,
   input  wire logic                           rsp_stall,
   input  wire sgr_pkg::rsp_payload_type       rsp_payload
);
   import sgr_pkg::*;

   logic req_take;
   logic rsp_take;
   logic rsp_wait;
   logic seq_take;
   logic end_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;
   assign rsp_wait = rsp_valid && rsp_stall;
   assign seq_take = rsp_take && rsp_payload.sequence_last;
   assign end_take = req_take && req_payload.list_end;

   // A stalled result holds.
   `SGR_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_valid && $stable(rsp_payload), "result changed")
   // The end of the sequence is always the end of a run.
   `SGR_ASSERT_NOW(a_seq_run, seq_take, rsp_payload.run_last, "sequence_last without run_last")
   // A list end always starts an emission, so input stalls right after.
   `SGR_ASSERT_NEXT(a_end_stall, end_take, req_stall, "no emission after list end")
   // Reset empties the result side.
   `SGR_ASSERT_ALWAYS(a_reset_empty, reset, !rsp_valid, "result valid after reset")

endmodule

bind stream_group_reverser_unit sgr_checker u_sgr_checker (.*);

`default_nettype wire

[verif/sgr_reorder_checker.sv]
// Checker for the group reverser: predicts each reordered word and compares it with the output.
module sgr_reorder_checker
   import sgr_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  req_payload_type      req_payload,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  rsp_payload_type      rsp_payload,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CFG_W-1:0]     csr_data,
   output int unsigned          fail_count,
   output int unsigned          pending_count,
   output int unsigned          results_seen
);

   logic signed [VALUE_W-1:0] group_words [GROUP_MAX];
   int                        open_count = 0;
   logic [CFG_W-1:0]          group_size = GROUP_SIZE_RESET;
   rsp_payload_type           reordered_q [$];
   int unsigned               errors = 0;
   int unsigned               seen = 0;

   assign fail_count   = errors;
   assign results_seen = seen;

   task automatic note_failure(input string what);
      errors++;
      if (errors <= 10) $display("MISMATCH at %0t: %s", $realtime, what);
   endtask

   // Buffer one word; emit the group reversed when full, in order when the list ends early.
   function automatic void reorder_item(input req_payload_type item);
      int k;
      int n;
      int i;
      rsp_payload_type word;
      if (group_size == '0) k = 1;
      else if (group_size > GROUP_MAX) k = GROUP_MAX;
      else k = int'(group_size);
      if (open_count >= GROUP_MAX) open_count = 0;
      group_words[open_count] = item.item_value;
      open_count++;
      n = open_count;
      if (n >= k || item.list_end) begin
         for (i = 0; i < n; i++) begin
            word.out_value     = (n >= k) ? group_words[n-1-i] : group_words[i];
            word.run_last      = (i == n - 1);
            word.sequence_last = (i == n - 1) && item.list_end;
            reordered_q.insert(reordered_q.size(), word);
         end
         open_count = 0;
      end
   endfunction

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (reordered_q.size() == 0) begin
         note_failure($sformatf("unexpected result: value %0d run_last %0b sequence_last %0b",
                                got.out_value, got.run_last, got.sequence_last));
         return;
      end
      want = reordered_q.pop_front();
      if (got.out_value !== want.out_value)
         note_failure($sformatf("out_value expected %0d, got %0d",
                                want.out_value, got.out_value));
      if (got.run_last !== want.run_last)
         note_failure($sformatf("run_last expected %0b, got %0b",
                                want.run_last, got.run_last));
      if (got.sequence_last !== want.sequence_last)
         note_failure($sformatf("sequence_last expected %0b, got %0b",
                                want.sequence_last, got.sequence_last));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         open_count = 0;
         group_size = GROUP_SIZE_RESET;
         reordered_q.delete();
      end else begin
         if (csr_valid && csr_ready) group_size = csr_data;
         if (req_valid && !req_stall) reorder_item(req_payload);
         if (rsp_valid && !rsp_stall) begin
            seen++;
            check_result(rsp_payload);
         end
      end
      pending_count <= reordered_q.size();
   end

endmodule

[verif/tb.sv]
// Top of the group reverser testbench: drives word lists and group sizes, gives the verdict.
module tb;
   import sgr_pkg::*;

   localparam int RESET_CYCLES    = 7;
   localparam int SETTLE_CYCLES   = 8;
   localparam int PRESSURE_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 400000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   req_payload_type  req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   rsp_payload_type  rsp_payload;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [CFG_W-1:0] csr_data = '0;

   int unsigned fail_count;
   int unsigned pending_count;
   int unsigned results_seen;
   int unsigned cycle_count = 0;
   int unsigned items_sent = 0;
   int unsigned size_writes = 0;
   bit          quiet = 1'b0;
   bit          pressure_req = 1'b0;
   bit          pressure_done = 1'b0;

   stream_group_reverser_unit i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   sgr_reorder_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .results_seen  (results_seen)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result side: random stall bursts, one long hold on request, none in the quiet tail.
   initial begin : drive_rsp_stall
      forever begin
         @(posedge clock);
         if (pressure_req && !pressure_done) begin
            rsp_stall <= 1'b1;
            repeat (PRESSURE_CYCLES) @(posedge clock);
            pressure_done = 1'b1;
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   function automatic logic signed [VALUE_W-1:0] random_word();
      case ($urandom_range(0, 7))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -32'sd1;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_item(input logic signed [VALUE_W-1:0] value, input logic ends_list);
      req_payload <= '{item_value: value, list_end: ends_list};
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      items_sent++;
      // keep offering during the long hold so the block backs up
      if (!quiet && !(pressure_req && !pressure_done) && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_group_size(input logic [CFG_W-1:0] group_len);
      req_valid <= 1'b0;
      wait_drained();
      csr_data  <= group_len;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_writes++;
   endtask

   // Lists of random length around the group size; a few leave the list open.
   task automatic run_phase(input logic [CFG_W-1:0] group_len, input int count,
                            input bit hold);
      int eff;
      int list_len;
      int sent;
      int i;
      write_group_size(group_len);
      if (hold) pressure_req = 1'b1;
      eff = (group_len == '0) ? 1 : (group_len > GROUP_MAX) ? GROUP_MAX : int'(group_len);
      sent = 0;
      while (sent < count) begin
         list_len = $urandom_range(1, 2 * eff + 1);
         for (i = 0; i < list_len; i++)
            send_item(random_word(), (i == list_len - 1) && ($urandom_range(0, 7) != 0));
         sent += list_len;
      end
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // reset group size of two: full pair, then a single-word tail
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(-32'sd1, 1'b1);
      write_group_size(5'd1);
      send_item(32'sd0, 1'b0);
      send_item(32'sd5, 1'b1);
      // lower the size while two words are held
      write_group_size(5'd3);
      send_item(32'sd11, 1'b0);
      send_item(-32'sd22, 1'b0);
      write_group_size(5'd1);
      send_item(32'sd33, 1'b0);
      // zero acts as one, out-of-range acts as the buffer depth
      write_group_size(5'd0);
      send_item(-32'sd44, 1'b1);
      write_group_size(5'd31);
      send_item(32'sd55, 1'b0);
      send_item(-32'sd66, 1'b1);
      // full group closed by the list end
      write_group_size(5'd2);
      send_item(32'sd77, 1'b0);
      send_item(32'sd88, 1'b1);
      write_group_size(5'd4);
      send_item(32'sd1, 1'b0);
      send_item(32'sd2, 1'b0);
      send_item(32'sd3, 1'b1);

      run_phase(5'(GROUP_MAX), 15, 1'b0);
      run_phase(5'd1, 15, 1'b0);
      run_phase(5'($urandom_range(2, GROUP_MAX - 1)), 15, 1'b0);
      run_phase(5'd4, 30, 1'b1);
      run_phase(5'd0, 10, 1'b0);
      run_phase(5'($urandom_range(GROUP_MAX + 1, 31)), 15, 1'b0);
      run_phase(5'($urandom_range(1, GROUP_MAX)), 10, 1'b0);
      quiet = 1'b1;
      run_phase(5'($urandom_range(1, GROUP_MAX)), 10, 1'b0);
      req_valid <= 1'b0;

      wait_drained();
      repeat (2 * SETTLE_CYCLES) @(posedge clock);
      $display("Ran %0d words and checked %0d results across %0d group size writes,",
               items_sent, results_seen, size_writes);
      $display("including sizes 0, 1, 16 and above 16 and a %0d-cycle result hold.",
               PRESSURE_CYCLES);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
